// ----- rtl/core/bols_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package bols_pkg;

	localparam int CAPACITY   = 16;
	localparam int VALUE_BITS = 32;

	localparam int IDX_W   = $clog2(CAPACITY);
	localparam int CNT_W   = $clog2(CAPACITY + 1);
	localparam int IN_W    = 32;
	localparam int CMD_W   = 2;
	localparam int STAT_W  = 2;
	localparam int POS_W   = 4;
	localparam int COUNT_W = 5;

	localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
	localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;

	localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
	localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

	typedef logic [VALUE_BITS-1:0] word_t;
	typedef logic [IDX_W-1:0]      idx_t;
	typedef logic [CNT_W-1:0]      cnt_t;

	typedef struct packed {
		logic  rd_en;
		idx_t  rd_pos;
		logic  wr_en;
		idx_t  wr_pos;
		word_t wr_data;
		logic  push;
	} mem_req_t;

	function automatic word_t from_input(input logic [IN_W-1:0] v);
		logic signed [63:0] w;
		w = 64'(signed'(v));
		return w[VALUE_BITS-1:0];
	endfunction

	function automatic logic [IN_W-1:0] to_output(input word_t s);
		logic signed [63:0] w;
		w = 64'(signed'(s));
		return w[IN_W-1:0];
	endfunction

	function automatic idx_t wrap_add(input idx_t a, input idx_t b);
		logic [IDX_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		if (s >= (IDX_W + 1)'(CAPACITY)) begin
			s = s - (IDX_W + 1)'(CAPACITY);
		end
		return s[IDX_W-1:0];
	endfunction

	function automatic idx_t wrap_dec(input idx_t a);
		return (a == '0) ? IDX_W'(CAPACITY - 1) : a - 1'b1;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bols_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// circular entry store: logical position 0 sits at the head pointer
module bols_mem (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire bols_pkg::mem_req_t req,
	output bols_pkg::word_t         rd_data
);

	bols_pkg::word_t mem_q [bols_pkg::CAPACITY];
	bols_pkg::idx_t  head_q;
	bols_pkg::idx_t  wr_phys;
	bols_pkg::idx_t  rd_phys;

	always_comb begin
		rd_phys = bols_pkg::wrap_add(head_q, req.rd_pos);
		if (req.push) begin
			wr_phys = bols_pkg::wrap_dec(head_q);
		end else begin
			wr_phys = bols_pkg::wrap_add(head_q, req.wr_pos);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
		end else if (req.push) begin
			head_q <= bols_pkg::wrap_dec(head_q);
		end
	end

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem_q[wr_phys] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_data <= mem_q[rd_phys];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/bounded_ordered_list_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake    | payload
// ----------+--------------+--------------------------------------------------
// command   | start / busy | command, value
// result    | done         | status, position, has_next, next_value, count
//
// Insert and unused commands answer in the cycle after acceptance.
// Find walks the entries at one memory read per cycle.
// Remove then shifts each later entry up, one per cycle.
// The single memory read port sets these rates.
// Reset clears the count and head pointer; entry contents are not cleared.
// done is a one-cycle strobe; the receiver cannot stall it.
module bounded_ordered_list_store (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  start,
	output logic                                       busy,
	input  wire logic [bols_pkg::CMD_W-1:0]            command,
	input  wire logic signed [bols_pkg::IN_W-1:0]      value,
	output logic                                       done,
	output logic [bols_pkg::STAT_W-1:0]                status,
	output logic [bols_pkg::POS_W-1:0]                 position,
	output logic                                       has_next,
	output logic signed [bols_pkg::IN_W-1:0]           next_value,
	output logic [bols_pkg::COUNT_W-1:0]               count
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_SHIFT = 2'd2;

	logic [1:0]                    state_q;
	logic [bols_pkg::CMD_W-1:0]    cmd_q;
	bols_pkg::word_t               val_q;
	bols_pkg::cnt_t                held_q;
	bols_pkg::cnt_t                idx_q;
	bols_pkg::idx_t                rem_pos_q;
	logic                          pend_s1;
	bols_pkg::idx_t                pos_s1;
	logic                          done_q;
	logic [bols_pkg::STAT_W-1:0]   status_q;
	bols_pkg::idx_t                pos_q;
	logic                          hn_q;
	logic [bols_pkg::IN_W-1:0]     nv_q;

	bols_pkg::mem_req_t            req;
	bols_pkg::word_t               rd_data;
	logic                          hit;
	logic                          full;
	logic                          walk_end;

	bols_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	assign busy       = (state_q != S_IDLE);
	assign done       = done_q;
	assign status     = status_q;
	assign position   = bols_pkg::POS_W'(pos_q);
	assign has_next   = hn_q;
	assign next_value = nv_q;
	assign count      = bols_pkg::COUNT_W'(held_q);

	assign full     = (held_q == bols_pkg::CNT_W'(bols_pkg::CAPACITY));
	assign hit      = pend_s1 && (rd_data == val_q);
	assign walk_end = !pend_s1 && !req.rd_en;

	always_comb begin
		req         = '0;
		req.wr_data = bols_pkg::from_input(value);
		unique case (state_q)
			S_IDLE: begin
				if (start && command == bols_pkg::CMD_INSERT && !full) begin
					req.wr_en = 1'b1;
					req.push  = 1'b1;
				end
			end
			S_SCAN: begin
				req.rd_en  = (idx_q < held_q);
				req.rd_pos = idx_q[bols_pkg::IDX_W-1:0];
			end
			S_SHIFT: begin
				req.rd_en   = (idx_q < held_q);
				req.rd_pos  = idx_q[bols_pkg::IDX_W-1:0];
				req.wr_en   = pend_s1;
				req.wr_pos  = pos_s1 - 1'b1;
				req.wr_data = rd_data;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			held_q  <= '0;
			idx_q   <= '0;
			pend_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					pend_s1 <= 1'b0;
					done_q  <= start && command != bols_pkg::CMD_FIND &&
					           command != bols_pkg::CMD_REMOVE;
					if (start) begin
						idx_q <= '0;
						if (command == bols_pkg::CMD_INSERT) begin
							if (!full) begin
								held_q <= held_q + 1'b1;
							end
						end else if (command == bols_pkg::CMD_FIND ||
						             command == bols_pkg::CMD_REMOVE) begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (hit && cmd_q == bols_pkg::CMD_REMOVE) begin
						idx_q   <= bols_pkg::CNT_W'(pos_s1) + 1'b1;
						pend_s1 <= 1'b0;
						done_q  <= 1'b0;
						state_q <= S_SHIFT;
					end else begin
						pend_s1 <= req.rd_en;
						if (req.rd_en) begin
							idx_q <= idx_q + 1'b1;
						end
						done_q <= hit || walk_end;
						if (hit || walk_end) begin
							state_q <= S_IDLE;
						end
					end
				end
				S_SHIFT: begin
					pend_s1 <= req.rd_en;
					if (req.rd_en) begin
						idx_q <= idx_q + 1'b1;
					end
					done_q <= walk_end;
					if (walk_end) begin
						held_q  <= held_q - 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: begin
					pend_s1 <= 1'b0;
					done_q  <= 1'b0;
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		pos_s1 <= req.rd_pos;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd_q    <= command;
					val_q    <= bols_pkg::from_input(value);
					pos_q    <= '0;
					hn_q     <= 1'b0;
					nv_q     <= '0;
					status_q <= (command != bols_pkg::CMD_INSERT) ? bols_pkg::ST_NOMATCH :
					            full ? bols_pkg::ST_FULL : bols_pkg::ST_DONE;
				end
			end
			S_SCAN: begin
				if (hit) begin
					pos_q     <= pos_s1;
					rem_pos_q <= pos_s1;
					status_q  <= bols_pkg::ST_DONE;
				end
			end
			S_SHIFT: begin
				if (pend_s1 && !hn_q) begin
					hn_q <= 1'b1;
					nv_q <= bols_pkg::to_output(rd_data);
				end
				pos_q <= rem_pos_q;
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam logic [bols_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic [31:0] V_MAX  = 32'h7FFF_FFFF;
	localparam logic [31:0] V_MIN  = 32'h8000_0000;
	localparam logic [31:0] V_NEG1 = 32'hFFFF_FFFF;
	localparam logic [31:0] V_FILL = 32'h5555_5555;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_TXNS = 1430;
	localparam int PLAN_ROWS = 15;

	typedef struct packed {
		logic [bols_pkg::STAT_W-1:0]  status;
		logic [bols_pkg::POS_W-1:0]   position;
		logic                         has_next;
		logic [bols_pkg::IN_W-1:0]    next_value;
		logic [bols_pkg::COUNT_W-1:0] count;
	} list_reply_t;

	typedef struct packed {
		logic [bols_pkg::CMD_W-1:0] cmd;
		logic [31:0]                val;
		logic [7:0]                 reps;
		logic                       typed;
		list_reply_t                reply;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [bols_pkg::CMD_W-1:0] command = '0;
	logic signed [bols_pkg::IN_W-1:0] value = '0;
	logic busy, done, has_next;
	logic [bols_pkg::STAT_W-1:0] status;
	logic [bols_pkg::POS_W-1:0] position;
	logic signed [bols_pkg::IN_W-1:0] next_value;
	logic [bols_pkg::COUNT_W-1:0] count;

	bounded_ordered_list_store dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.command(command), .value(value), .done(done), .status(status),
		.position(position), .has_next(has_next), .next_value(next_value),
		.count(count)
	);

	always #5 clk = ~clk;

	bols_pkg::word_t model_list [bols_pkg::CAPACITY];
	int model_held = 0;
	list_reply_t pending_results [$];
	int accepted_txns = 0;
	int errors = 0;
	int idle_cycles = 0;
	logic row_typed = 1'b0;
	list_reply_t row_reply = '0;
	int burst_left = 0;
	plan_row_t plan [PLAN_ROWS];

	function automatic list_reply_t apply_list_op(input logic [bols_pkg::CMD_W-1:0] op,
			input logic [31:0] raw);
		list_reply_t r;
		bols_pkg::word_t key;
		int hit;
		int i;
		logic signed [63:0] wide;
		logic signed [bols_pkg::VALUE_BITS-1:0] narrow;
		wide = signed'(raw);
		key = wide[bols_pkg::VALUE_BITS-1:0];
		r = '0;
		r.status = bols_pkg::ST_NOMATCH;
		hit = -1;
		for (i = 0; i < model_held; i++)
			if (hit < 0 && model_list[i] == key)
				hit = i;
		case (op)
			bols_pkg::CMD_INSERT: begin
				if (model_held >= bols_pkg::CAPACITY) begin
					r.status = bols_pkg::ST_FULL;
				end else begin
					for (i = model_held; i > 0; i--)
						model_list[i] = model_list[i - 1];
					model_list[0] = key;
					model_held++;
					r.status = bols_pkg::ST_DONE;
				end
			end
			bols_pkg::CMD_FIND: begin
				if (hit >= 0) begin
					r.status = bols_pkg::ST_DONE;
					r.position = bols_pkg::POS_W'(hit);
				end
			end
			bols_pkg::CMD_REMOVE: begin
				if (hit >= 0) begin
					r.status = bols_pkg::ST_DONE;
					r.position = bols_pkg::POS_W'(hit);
					if (hit + 1 < model_held) begin
						r.has_next = 1'b1;
						narrow = model_list[hit + 1];
						wide = narrow;
						r.next_value = wide[bols_pkg::IN_W-1:0];
					end
					for (i = hit; i + 1 < model_held; i++)
						model_list[i] = model_list[i + 1];
					model_held--;
				end
			end
			default: ;
		endcase
		r.count = bols_pkg::COUNT_W'(model_held);
		return r;
	endfunction

	// result check first, then record the transaction accepted at this edge
	always @(posedge clk) begin
		list_reply_t got, want, predicted;
		if (arst_n) begin
			if (done) begin
				got = '{status, position, has_next, next_value, count};
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result: status %0d position %0d",
						$time, got.status, got.position,
						" has_next %0d next %h count %0d",
						got.has_next, got.next_value, got.count);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						$display("%0t mismatch expected: status %0d position %0d",
							$time, want.status, want.position,
							" has_next %0d next %h count %0d",
							want.has_next, want.next_value, want.count);
						$display("%0t mismatch actual:   status %0d position %0d",
							$time, got.status, got.position,
							" has_next %0d next %h count %0d",
							got.has_next, got.next_value, got.count);
						errors++;
					end
				end
			end
			if (start && !busy) begin
				predicted = apply_list_op(command, value);
				pending_results.push_back(row_typed ? row_reply : predicted);
				accepted_txns++;
			end
			if ((start && !busy) || done)
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("FAIL bounded_ordered_list_store");
				$finish;
			end
		end
	end

	task automatic send_txn(input logic [bols_pkg::CMD_W-1:0] cmd, input logic [31:0] val);
		int target;
		target = accepted_txns + 1;
		start <= 1'b1;
		command <= cmd;
		value <= val;
		do @(negedge clk); while (accepted_txns < target);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 3);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150)
				: $urandom_range(1, 12);
		end
	endtask

	initial begin
		logic [31:0] pool [6];
		logic [bols_pkg::CMD_W-1:0] op;
		logic [31:0] pick;
		int mode, roll, ins_cut, find_cut, rem_cut;

		plan = '{
			'{bols_pkg::CMD_FIND,   32'h0,  8'd1,  1'b1,
				'{bols_pkg::ST_NOMATCH, 4'd0, 1'b0, 32'h0, 5'd0}},
			'{bols_pkg::CMD_REMOVE, 32'h5,  8'd1,  1'b1,
				'{bols_pkg::ST_NOMATCH, 4'd0, 1'b0, 32'h0, 5'd0}},
			'{CMD_UNUSED,           32'h0,  8'd1,  1'b1,
				'{bols_pkg::ST_NOMATCH, 4'd0, 1'b0, 32'h0, 5'd0}},
			'{bols_pkg::CMD_INSERT, V_MAX,  8'd1,  1'b1,
				'{bols_pkg::ST_DONE, 4'd0, 1'b0, 32'h0, 5'd1}},
			'{bols_pkg::CMD_INSERT, V_MIN,  8'd1,  1'b1,
				'{bols_pkg::ST_DONE, 4'd0, 1'b0, 32'h0, 5'd2}},
			'{bols_pkg::CMD_INSERT, 32'h0,  8'd1,  1'b1,
				'{bols_pkg::ST_DONE, 4'd0, 1'b0, 32'h0, 5'd3}},
			'{bols_pkg::CMD_INSERT, V_NEG1, 8'd1,  1'b1,
				'{bols_pkg::ST_DONE, 4'd0, 1'b0, 32'h0, 5'd4}},
			'{bols_pkg::CMD_FIND,   V_MAX,  8'd1,  1'b0, '0},
			'{bols_pkg::CMD_INSERT, 32'h0,  8'd1,  1'b1,
				'{bols_pkg::ST_DONE, 4'd0, 1'b0, 32'h0, 5'd5}},
			'{bols_pkg::CMD_FIND,   32'h0,  8'd1,  1'b0, '0},
			'{bols_pkg::CMD_REMOVE, 32'h0,  8'd1,  1'b0, '0},
			'{bols_pkg::CMD_INSERT, V_FILL, 8'd12, 1'b0, '0},
			'{bols_pkg::CMD_INSERT, 32'h1,  8'd1,  1'b1,
				'{bols_pkg::ST_FULL, 4'd0, 1'b0, 32'h0, 5'd16}},
			'{bols_pkg::CMD_REMOVE, V_MAX,  8'd1,  1'b0, '0},
			'{bols_pkg::CMD_FIND,   V_FILL, 8'd1,  1'b0, '0}
		};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < PLAN_ROWS; r++) begin
			for (int k = 0; k < plan[r].reps; k++) begin
				row_typed = plan[r].typed;
				row_reply = plan[r].reply;
				send_txn(plan[r].cmd, plan[r].val);
				pace_sender();
			end
		end
		row_typed = 1'b0;

		mode = 0;
		for (int n = 0; n < RANDOM_TXNS; n++) begin
			if (n % 250 == 0) begin
				pool[0] = V_MIN;
				pool[1] = V_MAX;
				for (int p = 2; p < 6; p++)
					pool[p] = $urandom;
			end
			if (n % 60 == 0)
				mode = $urandom_range(0, 2);
			ins_cut = (mode == 0) ? 65 : (mode == 1) ? 20 : 35;
			find_cut = ins_cut + ((mode == 0) ? 15 : (mode == 1) ? 20 : 30);
			rem_cut = 97;
			roll = $urandom_range(0, 99);
			op = (roll < ins_cut) ? bols_pkg::CMD_INSERT
				: (roll < find_cut) ? bols_pkg::CMD_FIND
				: (roll < rem_cut) ? bols_pkg::CMD_REMOVE : CMD_UNUSED;
			roll = $urandom_range(0, 99);
			if (roll < 35 && model_held > 0 && op != bols_pkg::CMD_INSERT)
				pick = model_list[$urandom_range(0, model_held - 1)];
			else if (roll < 80)
				pick = pool[$urandom_range(0, 5)];
			else
				pick = $urandom;
			send_txn(op, pick);
			pace_sender();
		end

		start <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
		if (errors == 0) begin
			$display("PASS bounded_ordered_list_store");
		end else begin
			$display("FAIL bounded_ordered_list_store");
		end
		$finish;
	end

endmodule
